/* rtl/brb_pkg.sv */
`timescale 1ns / 1ps

package brb_pkg;

    localparam int ACT_W  = 3;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 3;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int RES_W  = 10;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OVERRIDE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_XOR      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DISTANCE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] APPEND_MAX   = 3'd4;
    localparam logic [CNT_W-1:0] OVERRIDE_MAX = 3'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic eval;
        logic wr_byte;
        logic get_read;
        logic get_take;
        logic xor_issue;
        logic xor_acc;
        logic load_out;
    } brb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic act_append;
        logic act_get;
        logic act_override;
        logic act_xor;
        logic pos_bad;
        logic range_bad;
        logic buf_empty;
        logic at_end;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } brb_stat_t;

endpackage

/* rtl/brb_ctrl.sv */
`timescale 1ns / 1ps

module brb_ctrl import brb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  brb_stat_t stat,
    output brb_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_WRITE    = 3'd3;
    localparam logic [2:0] S_GET      = 3'd4;
    localparam logic [2:0] S_XOR      = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.eval = 1'b1;
                if (stat.act_append) begin
                    state_next = stat.cnt_zero ? S_FINISH : S_WRITE;
                end else if (stat.act_override) begin
                    state_next = (stat.pos_bad || stat.cnt_zero) ? S_FINISH : S_WRITE;
                end else if (stat.act_get) begin
                    if (stat.buf_empty) begin
                        state_next = S_FINISH;
                    end else begin
                        cmd.get_read = 1'b1;
                        state_next   = S_GET;
                    end
                end else if (stat.act_xor) begin
                    if (stat.range_bad || stat.at_end) begin
                        state_next = S_FINISH;
                    end else begin
                        cmd.xor_issue = 1'b1;
                        state_next    = S_XOR;
                    end
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_WRITE: begin
                cmd.wr_byte = 1'b1;
                if (stat.cnt_one) begin
                    state_next = S_FINISH;
                end
            end
            S_GET: begin
                cmd.get_take = 1'b1;
                state_next   = S_FINISH;
            end
            S_XOR: begin
                // Fold the byte read last cycle while the next one is read.
                cmd.xor_acc = 1'b1;
                if (stat.at_end) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.xor_issue = 1'b1;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/brb_datapath.sv */
`timescale 1ns / 1ps

module brb_datapath import brb_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [VAL_W-1:0]  s_value,
    input  logic [CNT_W-1:0]  s_byte_count,
    input  logic [POS_W-1:0]  s_position,
    input  logic [POS_W-1:0]  s_end_position,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [DATA_W-1:0] m_read_data,
    output logic [STAT_W-1:0] m_status,
    output logic [RES_W-1:0]  m_write_position,
    output logic [RES_W-1:0]  m_result_value,
    input  brb_cmd_t          cmd,
    output brb_stat_t         stat
);

    localparam int SIZE_MAX = (DEPTH < 2047) ? DEPTH : 2047;
    localparam int IDX_W    = (SIZE_MAX > 1) ? $clog2(SIZE_MAX) : 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CFG_W-1:0]  SIZE_CAP  = CFG_W'(SIZE_MAX);

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CFG_W-1:0] size);
        logic [CFG_W-1:0] nx;
        nx = CFG_W'(idx) + CFG_W'(1);
        return (nx >= size) ? '0 : IDX_W'(nx);
    endfunction

    logic [CFG_W-1:0]  buffer_size_reg;
    logic [CFG_W-1:0]  size_eff;

    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [ACT_W-1:0]  act_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  end_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_we;
    logic              mem_re;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_read_data_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [RES_W-1:0]  m_write_position_reg;
    logic [RES_W-1:0]  m_result_value_reg;

    logic              pos_bad;
    logic              range_bad;
    logic [CFG_W-1:0]  pos_ext;
    logic [CFG_W-1:0]  end_ext;
    logic [CFG_W-1:0]  gap;
    logic [RES_W-1:0]  result_next;

    // A size of zero acts as one, and a size beyond the store acts as the store size.
    always_comb begin
        if (buffer_size_reg == '0) begin
            size_eff = CFG_W'(1);
        end else if (buffer_size_reg > SIZE_CAP) begin
            size_eff = SIZE_CAP;
        end else begin
            size_eff = buffer_size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            buffer_size_reg <= cfg_wr_data;
        end
    end

    assign pos_ext   = CFG_W'(pos_reg);
    assign end_ext   = CFG_W'(end_reg);
    assign pos_bad   = pos_ext >= size_eff;
    assign range_bad = pos_bad || (end_ext >= size_eff);

    // The sum stays below the effective size, so it does not wrap in 11 bits; the result keeps the low 10 bits.
    assign gap = (pos_ext < end_ext) ? (end_ext - pos_ext) :
                 (pos_ext > end_ext) ? (size_eff - pos_ext + end_ext) : '0;

    always_comb begin
        stat              = '0;
        stat.clear_last   = clr_addr_reg == LAST_ADDR;
        stat.act_append   = act_reg == ACT_APPEND;
        stat.act_get      = act_reg == ACT_GET;
        stat.act_override = act_reg == ACT_OVERRIDE;
        stat.act_xor      = act_reg == ACT_XOR;
        stat.pos_bad      = pos_bad;
        stat.range_bad    = range_bad;
        stat.buf_empty    = wr_idx_reg == rd_idx_reg;
        stat.at_end       = CFG_W'(cur_reg) == end_ext;
        stat.cnt_zero     = cnt_reg == '0;
        stat.cnt_one      = cnt_reg == CNT_W'(1);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    always_comb begin
        if (s_action == ACT_APPEND) begin
            cnt_next = (s_byte_count > APPEND_MAX) ? APPEND_MAX : s_byte_count;
        end else begin
            cnt_next = (s_byte_count > OVERRIDE_MAX) ? OVERRIDE_MAX : s_byte_count;
        end
    end

    always_comb begin
        status_next = STAT_OK;
        if ((act_reg == ACT_GET) && (wr_idx_reg == rd_idx_reg)) begin
            status_next = STAT_EMPTY;
        end else if ((act_reg == ACT_OVERRIDE) && pos_bad) begin
            status_next = STAT_RANGE;
        end else if (((act_reg == ACT_XOR) || (act_reg == ACT_DISTANCE)) && range_bad) begin
            status_next = STAT_RANGE;
        end
    end

    always_comb begin
        mem_addr  = ADDR_W'(cur_reg);
        mem_wdata = value_reg[DATA_W-1:0];
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (cmd.clr_step) begin
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
            mem_we    = 1'b1;
        end else if (cmd.wr_byte) begin
            mem_addr = (act_reg == ACT_APPEND) ? ADDR_W'(wr_idx_reg) : ADDR_W'(cur_reg);
            mem_we   = 1'b1;
        end else if (cmd.get_read) begin
            mem_addr = ADDR_W'(rd_idx_reg);
            mem_re   = 1'b1;
        end else if (cmd.xor_issue) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            if (cmd.wr_byte && (act_reg == ACT_APPEND)) begin
                wr_idx_reg <= advance(wr_idx_reg, size_eff);
            end
            if (cmd.get_take) begin
                rd_idx_reg <= advance(rd_idx_reg, size_eff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg       <= s_action;
            value_reg     <= s_value;
            cnt_reg       <= cnt_next;
            pos_reg       <= s_position;
            end_reg       <= s_end_position;
            cur_reg       <= IDX_W'(s_position);
            read_data_reg <= '0;
            acc_reg       <= '0;
        end else begin
            if (cmd.wr_byte) begin
                value_reg <= value_reg >> DATA_W;
                cnt_reg   <= cnt_reg - CNT_W'(1);
                if (act_reg != ACT_APPEND) begin
                    cur_reg <= advance(cur_reg, size_eff);
                end
            end
            if (cmd.xor_issue) begin
                cur_reg <= advance(cur_reg, size_eff);
            end
            if (cmd.xor_acc) begin
                acc_reg <= acc_reg ^ mem_rdata_reg;
            end
            if (cmd.get_take) begin
                read_data_reg <= mem_rdata_reg;
            end
        end
        if (cmd.eval) begin
            status_reg <= status_next;
        end
    end

    always_comb begin
        result_next = '0;
        if (status_reg == STAT_OK) begin
            if (act_reg == ACT_XOR) begin
                result_next = RES_W'(acc_reg);
            end else if (act_reg == ACT_DISTANCE) begin
                result_next = gap[RES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_read_data_reg      <= read_data_reg;
            m_status_reg         <= status_reg;
            m_write_position_reg <= RES_W'(wr_idx_reg);
            m_result_value_reg   <= result_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = m_read_data_reg;
    assign m_status         = m_status_reg;
    assign m_write_position = m_write_position_reg;
    assign m_result_value   = m_result_value_reg;

endmodule

/* rtl/byte_ring_buffer_with_xor.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Content
// s_       in         s_valid/s_ready    action, value, byte_count, position, end_position
// m_       out        m_valid/m_ready    read_data, status, write_position, result_value
// cfg_     in         cfg_wr_en          buffer_size, written at once, no read-back
//
// One item at a time, through a single-port byte memory: it is captured, dispatched,
// writes its bytes (append, override), walks its span (xor) or reads one byte (a get
// that finds one), then loads its result; items with no such step go straight on.
// After reset a clearing pass zeroes all of the memory, one byte a cycle, with s_ready
// low; configuration writes are taken meanwhile.
// One result register sits on the output: the next item is accepted while a result
// waits there, and a finished item holds until that register is free.

module byte_ring_buffer_with_xor import brb_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [VAL_W-1:0]  s_value,
    input  logic [CNT_W-1:0]  s_byte_count,
    input  logic [POS_W-1:0]  s_position,
    input  logic [POS_W-1:0]  s_end_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [STAT_W-1:0] m_status,
    output logic [RES_W-1:0]  m_write_position,
    output logic [RES_W-1:0]  m_result_value
);

    brb_cmd_t  cmd;
    brb_stat_t stat;

    brb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    brb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_action         (s_action),
        .s_value          (s_value),
        .s_byte_count     (s_byte_count),
        .s_position       (s_position),
        .s_end_position   (s_end_position),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_read_data      (m_read_data),
        .m_status         (m_status),
        .m_write_position (m_write_position),
        .m_result_value   (m_result_value),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

/* tb/sv/byte_ring_buffer_with_xor_tb.sv */
`timescale 1ns / 1ps

module byte_ring_buffer_with_xor_tb;
    import brb_pkg::*;

    localparam int RING_DEPTH = 1024;
    // Longest correct silence: the clearing pass, or a full-ring xor behind a stall.
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int PLAN_LEN = 32;
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = ACT_DISTANCE + 3'd1;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST = '1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] byte_count;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] end_position;
    } ring_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic [RES_W-1:0]  write_position;
        logic [RES_W-1:0]  result_value;
    } ring_result_t;

    // One row of the directed plan: either a size write or an item, with the
    // result typed in when known is set.
    typedef struct packed {
        logic              cfg;
        logic [CFG_W-1:0]  size;
        logic [ACT_W-1:0]  act;
        logic [VAL_W-1:0]  val;
        logic [CNT_W-1:0]  cnt;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  endp;
        logic              known;
        logic [DATA_W-1:0] rd;
        logic [STAT_W-1:0] st;
        logic [RES_W-1:0]  wp;
        logic [RES_W-1:0]  res;
    } plan_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action = '0;
    logic [VAL_W-1:0]  s_value = '0;
    logic [CNT_W-1:0]  s_byte_count = '0;
    logic [POS_W-1:0]  s_position = '0;
    logic [POS_W-1:0]  s_end_position = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_read_data;
    logic [STAT_W-1:0] m_status;
    logic [RES_W-1:0]  m_write_position;
    logic [RES_W-1:0]  m_result_value;

    // Shadow copy of the ring and its indices.
    logic [7:0]       ring_mem [RING_DEPTH];
    int unsigned      wr_idx = 0;
    int unsigned      rd_idx = 0;
    logic [CFG_W-1:0] size_reg = SIZE_RESET;

    ring_result_t expected_results [$];
    ring_result_t oldest_result;
    bit           quiet = 1'b0;
    int           mismatch_count = 0;
    int           results_checked = 0;
    int           items_sent = 0;
    int           sizes_used = 1;
    int           stall_cycles = 0;

    logic [CFG_W-1:0] phase_sizes [PHASES] = '{
        11'd3, 11'd1, 11'd2, 11'd16, 11'd0, 11'd1024, 11'd7, 11'd2047, 11'd100, 11'd600
    };

    plan_row_t plan [PLAN_LEN] = '{
        '{1'b0, 11'd0, ACT_GET, 32'h0, 3'd0, 10'd0, 10'd0, 1'b1, 8'h00, STAT_EMPTY, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'hFFFF_FFFF, 3'd4, 10'd0, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd4, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'h0, 3'd1, 10'd0, 10'd0, 1'b1, 8'h00, STAT_OK, 10'd5, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'hDEAD, 3'd0, 10'd0, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd5, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'h1234_5678, 3'd7, 10'd0, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_GET, 32'h0, 3'd0, 10'd0, 10'd0, 1'b1, 8'hFF, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_OVERRIDE, 32'hA5C3, 3'd2, 10'd1023, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_OVERRIDE, 32'h00FF, 3'd6, 10'd3, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_OVERRIDE, 32'h0077, 3'd0, 10'd4, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_XOR, 32'h0, 3'd0, 10'd0, 10'd9, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_XOR, 32'h0, 3'd0, 10'd1023, 10'd2, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_XOR, 32'h0, 3'd0, 10'd7, 10'd7, 1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd5, 10'd5,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd1023, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd1},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd0, 10'd1023,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd1023},
        '{1'b0, 11'd0, ACT_SPARE_FIRST, 32'hFFFF_FFFF, 3'd7, 10'd1023, 10'd1023,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_SPARE_FIRST + 3'd1, 32'hFFFF_FFFF, 3'd4, 10'd0, 10'd5,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        '{1'b0, 11'd0, ACT_SPARE_LAST, 32'h0, 3'd1, 10'd2, 10'd1,
          1'b1, 8'h00, STAT_OK, 10'd9, 10'd0},
        // Shrink below the write index; the next append wraps the write index to zero.
        '{1'b1, 11'd4, ACT_APPEND, 32'h0, 3'd0, 10'd0, 10'd0, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'h5A, 3'd1, 10'd0, 10'd0, 1'b1, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_GET, 32'h0, 3'd0, 10'd0, 10'd0, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_OVERRIDE, 32'h11, 3'd1, 10'd4, 10'd0,
          1'b1, 8'h00, STAT_RANGE, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_XOR, 32'h0, 3'd0, 10'd0, 10'd4, 1'b1, 8'h00, STAT_RANGE, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd1023, 10'd0,
          1'b1, 8'h00, STAT_RANGE, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd3, 10'd1,
          1'b1, 8'h00, STAT_OK, 10'd0, 10'd2},
        // A size of zero behaves as one.
        '{1'b1, 11'd0, ACT_APPEND, 32'h0, 3'd0, 10'd0, 10'd0, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_APPEND, 32'h00C0_FFEE, 3'd3, 10'd0, 10'd0,
          1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_DISTANCE, 32'h0, 3'd0, 10'd0, 10'd0,
          1'b1, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_GET, 32'h0, 3'd0, 10'd0, 10'd0, 1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        // A size above the ring depth is clamped to the depth.
        '{1'b1, 11'd2047, ACT_APPEND, 32'h0, 3'd0, 10'd0, 10'd0,
          1'b0, 8'h00, STAT_OK, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_GET, 32'h0, 3'd0, 10'd0, 10'd0, 1'b1, 8'h00, STAT_EMPTY, 10'd0, 10'd0},
        '{1'b0, 11'd0, ACT_XOR, 32'h0, 3'd0, 10'd1023, 10'd1023,
          1'b1, 8'h00, STAT_OK, 10'd0, 10'd0}
    };

    byte_ring_buffer_with_xor #(
        .DEPTH(RING_DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_value         (s_value),
        .s_byte_count    (s_byte_count),
        .s_position      (s_position),
        .s_end_position  (s_end_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_status        (m_status),
        .m_write_position(m_write_position),
        .m_result_value  (m_result_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned size_in_effect();
        if (size_reg == '0) return 1;
        if (size_reg > CFG_W'(RING_DEPTH)) return RING_DEPTH;
        return 32'(size_reg);
    endfunction

    function automatic int unsigned next_index(input int unsigned idx, input int unsigned sz);
        return (idx + 1 >= sz) ? 0 : idx + 1;
    endfunction

    // Applies one item to the shadow ring and returns the result it must produce.
    function automatic ring_result_t predict_ring(input ring_op_t op);
        ring_result_t r;
        int unsigned  sz;
        int unsigned  cnt;
        int unsigned  p;
        int unsigned  i;
        logic [7:0]   folded;
        bit           bad;
        r = '0;
        sz = size_in_effect();
        cnt = op.byte_count;
        bad = (op.position >= sz) || (op.end_position >= sz);
        case (op.action)
            ACT_APPEND: begin
                if (cnt > APPEND_MAX) cnt = APPEND_MAX;
                for (i = 0; i < cnt; i++) begin
                    ring_mem[wr_idx] = op.value[8*i +: 8];
                    wr_idx = next_index(wr_idx, sz);
                end
            end
            ACT_GET: begin
                if (wr_idx != rd_idx) begin
                    r.read_data = ring_mem[rd_idx];
                    rd_idx = next_index(rd_idx, sz);
                end else begin
                    r.status = STAT_EMPTY;
                end
            end
            ACT_OVERRIDE: begin
                if (op.position >= sz) begin
                    r.status = STAT_RANGE;
                end else begin
                    if (cnt > OVERRIDE_MAX) cnt = OVERRIDE_MAX;
                    if (cnt >= 1) ring_mem[op.position] = op.value[7:0];
                    if (cnt == 2) ring_mem[next_index(op.position, sz)] = op.value[15:8];
                end
            end
            ACT_XOR: begin
                if (bad) begin
                    r.status = STAT_RANGE;
                end else begin
                    p = op.position;
                    folded = '0;
                    while (p != op.end_position) begin
                        folded ^= ring_mem[p];
                        p = next_index(p, sz);
                    end
                    r.result_value = RES_W'(folded);
                end
            end
            ACT_DISTANCE: begin
                if (bad) r.status = STAT_RANGE;
                else if (op.position < op.end_position)
                    r.result_value = op.end_position - op.position;
                else if (op.position > op.end_position)
                    r.result_value = RES_W'(sz - op.position + op.end_position);
            end
            default: begin
            end
        endcase
        r.write_position = RES_W'(wr_idx);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(input ring_op_t op, input bit typed, input ring_result_t typed_want);
        ring_result_t want;
        while (!quiet && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= op.action;
        s_value        <= op.value;
        s_byte_count   <= op.byte_count;
        s_position     <= op.position;
        s_end_position <= op.end_position;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_ring(op);
        if (typed) want = typed_want;
        expected_results.push_back(want);
        items_sent++;
        @(negedge aclk);
    endtask

    // The size only changes once every outstanding result has drained.
    task automatic write_size(input logic [CFG_W-1:0] new_size);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= new_size;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        size_reg = new_size;
        sizes_used++;
    endtask

    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                results_checked++;
                if (m_read_data !== oldest_result.read_data) begin
                    $error("read_data: expected %0h, got %0h",
                           oldest_result.read_data, m_read_data);
                    mismatch_count++;
                end
                if (m_status !== oldest_result.status) begin
                    $error("status: expected %0h, got %0h", oldest_result.status, m_status);
                    mismatch_count++;
                end
                if (m_write_position !== oldest_result.write_position) begin
                    $error("write_position: expected %0h, got %0h",
                           oldest_result.write_position, m_write_position);
                    mismatch_count++;
                end
                if (m_result_value !== oldest_result.result_value) begin
                    $error("result_value: expected %0h, got %0h",
                           oldest_result.result_value, m_result_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned  eff;
        int unsigned  pick;
        int unsigned  reach;
        ring_op_t     op;
        ring_result_t want;
        plan_row_t    row;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.cfg) begin
                write_size(row.size);
            end else begin
                op = '{row.act, row.val, row.cnt, row.pos, row.endp};
                want = '{row.rd, row.st, row.wp, row.res};
                push_item(op, row.known, want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_size((ph == 6) ? CFG_W'($urandom_range(3, 64)) : phase_sizes[ph]);
            // One phase runs with both sides always ready.
            quiet = (ph == 3);
            eff = size_in_effect();
            reach = (eff > 48) ? 40 : eff - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 30) op.action = ACT_APPEND;
                else if (pick < 60) op.action = ACT_GET;
                else if (pick < 72) op.action = ACT_OVERRIDE;
                else if (pick < 84) op.action = ACT_XOR;
                else if (pick < 96) op.action = ACT_DISTANCE;
                else op.action = ACT_SPARE_FIRST + ACT_W'($urandom_range(0, 2));
                op.value = $urandom();
                if ($urandom_range(99) < 88)
                    op.byte_count = (op.action == ACT_OVERRIDE) ?
                        CNT_W'($urandom_range(1, OVERRIDE_MAX)) :
                        CNT_W'($urandom_range(1, APPEND_MAX));
                else
                    op.byte_count = CNT_W'($urandom_range(0, 7));
                if ($urandom_range(99) < 88) op.position = POS_W'($urandom_range(0, eff - 1));
                else op.position = POS_W'($urandom_range(0, RING_DEPTH - 1));
                // Mostly short spans so xor walks stay cheap on a large ring.
                if ($urandom_range(99) < 90)
                    op.end_position = POS_W'((op.position + $urandom_range(0, reach)) % eff);
                else
                    op.end_position = POS_W'($urandom_range(0, RING_DEPTH - 1));
                push_item(op, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d items over %0d size settings and checked %0d results.",
                 items_sent, sizes_used, results_checked);
        $display({"Exercised empty gets, overruns, shrink wrap, clamped sizes and counts, ",
                  "and out-of-range positions."});
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
